>>> rtl/core/utt_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the job queue, the back end and the top level. No dependencies.
package utt_pkg;

    localparam int unsigned CpWidth         = 21;
    localparam int unsigned UnitWidth       = 16;
    localparam int unsigned QueueDepthDflt  = 2;
    localparam int unsigned ApbAddrWidth    = 3;
    localparam int unsigned ApbDataWidth    = 32;

    localparam logic [UnitWidth-1:0] HighFirst = 16'hD800;
    localparam logic [UnitWidth-1:0] HighLast  = 16'hDBFF;
    localparam logic [UnitWidth-1:0] LowFirst  = 16'hDC00;
    localparam logic [UnitWidth-1:0] LowLast   = 16'hDFFF;

    localparam logic [CpWidth-1:0] SuppBase   = 21'h10000;
    localparam logic [CpWidth-1:0] TwoByteMin = 21'h00080;
    localparam logic [CpWidth-1:0] ThreeByteMin = 21'h00800;

    localparam logic [7:0] Lead2    = 8'hC0;
    localparam logic [7:0] Lead3    = 8'hE0;
    localparam logic [7:0] Lead4    = 8'hF0;
    localparam logic [7:0] ContMark = 8'h80;

    // Register index of the byte order control.
    localparam logic RegBigEndian = 1'b0;

    // One job: up to two code points caused by one input item, plus the end flag.
    typedef struct packed {
        logic               has0;
        logic [CpWidth-1:0] cp0;
        logic               has1;
        logic [CpWidth-1:0] cp1;
        logic               last;
    } utt_job_t;

    // Number of UTF-8 bytes minus one for a code point.
    function automatic logic [1:0] utf8_lenm1(input logic [CpWidth-1:0] cp);
        logic [1:0] lenm1;
        if (cp < TwoByteMin)
            lenm1 = 2'd0;
        else if (cp < ThreeByteMin)
            lenm1 = 2'd1;
        else if (cp < SuppBase)
            lenm1 = 2'd2;
        else
            lenm1 = 2'd3;
        return lenm1;
    endfunction

    // Byte number idx of the UTF-8 sequence for cp.
    function automatic logic [7:0] utf8_byte(input logic [CpWidth-1:0] cp,
                                             input logic [1:0] lenm1,
                                             input logic [1:0] idx);
        logic [7:0] res;
        logic [1:0] grp;
        grp = lenm1 - idx;
        if (idx == 2'd0) begin
            case (lenm1)
                2'd0:    res = {1'b0, cp[6:0]};
                2'd1:    res = Lead2 | {3'b000, cp[10:6]};
                2'd2:    res = Lead3 | {4'b0000, cp[15:12]};
                default: res = Lead4 | {5'b00000, cp[20:18]};
            endcase
        end else begin
            case (grp)
                2'd0:    res = ContMark | {2'b00, cp[5:0]};
                2'd1:    res = ContMark | {2'b00, cp[11:6]};
                default: res = ContMark | {2'b00, cp[17:12]};
            endcase
        end
        return res;
    endfunction

endpackage

>>> rtl/core/utf16_to_utf8_transcoder_core.sv
// UTF-16 to UTF-8 transcoder core. A byte that completes a code unit is queued as a job, and
// the back end later loads its first UTF-8 byte into the output register. Throughput: one
// input item per cycle while the job queue has room; the back end sends one UTF-8 byte per
// cycle while the consumer takes them, so that serialiser sets the sustained pace (one to six
// output bytes per job). Reset (rst_n, asynchronous, active low) clears all pairing and surrogate
// state, empties the queue and the output register, and sets the byte order to little endian.
module utf16_to_utf8_transcoder_core
    import utt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDflt
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    byte_valid,
    output logic                    out_last,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ApbAddrWidth-1:0] paddr,
    input  logic [ApbDataWidth-1:0] pwdata,
    output logic [ApbDataWidth-1:0] prdata,
    output logic                    pready
);

    // The configuration register. The register index is the address divided by four; only the byte
    // order register exists, and writes to other indices are ignored. The front end reads it
    // directly, so software must change it only while the block is idle; the block does not enforce it.
    logic big_endian_reg;
    logic reg_write;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready && (paddr[2] == RegBigEndian);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            big_endian_reg <= 1'b0;
        else if (reg_write)
            big_endian_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == RegBigEndian)
            prdata[0] = big_endian_reg;
    end

    // The front end takes one item per cycle while the queue has room, pairs bytes into code
    // units and resolves surrogates. Each item that yields text, or that ends the stream, becomes
    // one job holding up to two code points.
    logic     queue_full;
    logic     push;
    utt_job_t push_job;
    logic     pop;
    logic     head_valid;
    utt_job_t head_job;

    utt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .big_endian (big_endian_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // The queue lets the front end keep accepting items while the back end is still
    // serialising earlier jobs or is stalled by the consumer.
    utt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The back end encodes the head job into UTF-8 one byte per cycle while the consumer is ready,
    // marks the final byte of an end-of-stream item and emits a bare end marker for one with no text.
    utt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .out_last   (out_last)
    );

endmodule

>>> rtl/core/utt_front.sv
// Front end of the transcoder: pairs bytes into UTF-16 units and resolves surrogates.
// Produces one job per item that yields output. Depends on utt_pkg.
module utt_front
    import utt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           big_endian,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           queue_full,
    output logic           push,
    output utt_job_t       push_job
);

    logic [7:0]           pending_byte_reg, pending_byte_next;
    logic                 have_pending_reg, have_pending_next;
    logic [UnitWidth-1:0] held_reg, held_next;
    logic                 have_held_reg, have_held_next;

    logic [UnitWidth-1:0] unit;
    logic                 is_high;
    logic                 is_low;
    logic                 accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign unit     = big_endian ? {pending_byte_reg, in_byte} : {in_byte, pending_byte_reg};
    assign is_high  = (unit >= HighFirst) && (unit <= HighLast);
    assign is_low   = (unit >= LowFirst) && (unit <= LowLast);

    always_comb
    begin
        logic               held_w;
        logic [UnitWidth-1:0] held_v;
        utt_job_t           job;

        held_w = have_held_reg;
        held_v = held_reg;
        job    = '0;
        job.last = in_last;

        pending_byte_next = pending_byte_reg;
        have_pending_next = have_pending_reg;

        if (!have_pending_reg) begin
            pending_byte_next = in_byte;
            have_pending_next = 1'b1;
        end else begin
            have_pending_next = 1'b0;
            if (held_w && is_low) begin
                job.has0 = 1'b1;
                job.cp0  = SuppBase + {1'b0, held_v[9:0], unit[9:0]};
                held_w   = 1'b0;
            end else begin
                if (held_w) begin
                    job.has0 = 1'b1;
                    job.cp0  = {{(CpWidth-UnitWidth){1'b0}}, held_v};
                    held_w   = 1'b0;
                end
                if (is_high) begin
                    held_w = 1'b1;
                    held_v = unit;
                end else if (job.has0) begin
                    job.has1 = 1'b1;
                    job.cp1  = {{(CpWidth-UnitWidth){1'b0}}, unit};
                end else begin
                    job.has0 = 1'b1;
                    job.cp0  = {{(CpWidth-UnitWidth){1'b0}}, unit};
                end
            end
        end

        if (in_last) begin
            // End of stream flushes a held surrogate and drops an odd byte.
            if (held_w) begin
                if (job.has0) begin
                    job.has1 = 1'b1;
                    job.cp1  = {{(CpWidth-UnitWidth){1'b0}}, held_v};
                end else begin
                    job.has0 = 1'b1;
                    job.cp0  = {{(CpWidth-UnitWidth){1'b0}}, held_v};
                end
            end
            held_w            = 1'b0;
            have_pending_next = 1'b0;
        end

        held_next      = held_v;
        have_held_next = held_w;
        push_job       = job;
        push           = accept && (job.has0 || in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            have_pending_reg <= 1'b0;
            have_held_reg    <= 1'b0;
            pending_byte_reg <= '0;
            held_reg         <= '0;
        end else if (accept) begin
            have_pending_reg <= have_pending_next;
            have_held_reg    <= have_held_next;
            pending_byte_reg <= pending_byte_next;
            held_reg         <= held_next;
        end
    end

endmodule

>>> rtl/core/utt_queue.sv
// Short job queue between the front end and the back end of the transcoder.
// Holds DEPTH jobs in a register array. Depends on utt_pkg.
module utt_queue
    import utt_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDflt
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  utt_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output utt_job_t head_job
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

    utt_job_t            mem_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full       = (count_reg == CntFull);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/core/utt_back.sv
// Back end of the transcoder: serialises each job into UTF-8 bytes, one per cycle unless stalled.
// Drives the registered output channel. Depends on utt_pkg.
module utt_back
    import utt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  utt_job_t head_job,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output logic [7:0] out_byte,
    output logic     byte_valid,
    output logic     out_last
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       out_last_reg, out_last_next;
    logic       sel_reg, sel_next;
    logic [1:0] idx_reg, idx_next;

    logic [CpWidth-1:0] cur_cp;
    logic [1:0]         lenm1;
    logic               cp_done;
    logic               last_cp;
    logic               advance;

    assign cur_cp  = sel_reg ? head_job.cp1 : head_job.cp0;
    assign lenm1   = utf8_lenm1(cur_cp);
    assign cp_done = (idx_reg == lenm1);
    assign last_cp = sel_reg || !head_job.has1;
    assign advance = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        out_last_next   = out_last_reg;
        sel_next        = sel_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;

        if (advance) begin
            out_valid_next = 1'b1;
            if (!head_job.has0) begin
                // Bare end marker for a final item that produced no text.
                out_byte_next   = '0;
                byte_valid_next = 1'b0;
                out_last_next   = 1'b1;
                pop             = 1'b1;
            end else begin
                out_byte_next   = utf8_byte(cur_cp, lenm1, idx_reg);
                byte_valid_next = 1'b1;
                out_last_next   = head_job.last && last_cp && cp_done;
                if (cp_done) begin
                    idx_next = '0;
                    if (last_cp) begin
                        sel_next = 1'b0;
                        pop      = 1'b1;
                    end else begin
                        sel_next = 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign out_last   = out_last_reg;

endmodule

>>> tb/utf16_to_utf8_transcoder_core_tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder core.
// Covers byte pairing in both orders, surrogate handling, end-of-stream flushing and back-pressure.
// Depends on utt_pkg and utf16_to_utf8_transcoder_core.
module utf16_to_utf8_transcoder_core_tb;
    import utt_pkg::*;

    // The byte order control is register 0, so it sits at byte address 0.
    localparam logic [ApbAddrWidth-1:0] BigEndianAddr = ApbAddrWidth'(4 * RegBigEndian);

    // One UTF-8 output item as the block presents it.
    typedef struct {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
    } utf8_item_t;

    // Clock and reset. Reset is asserted at the start and never again.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every input of the block has a known value from time zero.
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              in_byte = '0;
    logic                    in_last = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    out_last;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ApbAddrWidth-1:0] paddr = '0;
    logic [ApbDataWidth-1:0] pwdata = '0;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;

    utf16_to_utf8_transcoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .out_last   (out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Our own copy of the transcoder state, mirroring the block from reset onwards.
    logic        cfg_big_endian = 1'b0;
    logic [7:0]  unit_first_byte = '0;
    logic        unit_half_seen = 1'b0;
    logic [15:0] waiting_high = '0;
    logic        high_waiting = 1'b0;

    // UTF-8 items that the block still owes us, oldest first.
    utf8_item_t utf8_expected[$];

    int mismatches = 0;
    int items_sent = 0;
    int utf8_checked = 0;
    int end_markers = 0;
    int hold_cycles_done = 0;

    // Idling controls shared by the tests and the two handshake processes.
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_left = 0;

    // Every mismatch goes through here: one line each, and the count.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic push_utf8(input logic [7:0] b);
        utf8_item_t it;
        it.data = b;
        it.data_valid = 1'b1;
        it.last = 1'b0;
        utf8_expected.insert(utf8_expected.size(), it);
    endtask

    // Encodes one code point as one to four UTF-8 bytes.
    task automatic push_code_point(input logic [20:0] cp);
        if (cp < 21'h000080)
            push_utf8({1'b0, cp[6:0]});
        else if (cp < 21'h000800)
        begin
            push_utf8({3'b110, cp[10:6]});
            push_utf8({2'b10, cp[5:0]});
        end
        else if (cp < 21'h010000)
        begin
            push_utf8({4'b1110, cp[15:12]});
            push_utf8({2'b10, cp[11:6]});
            push_utf8({2'b10, cp[5:0]});
        end
        else
        begin
            push_utf8({5'b11110, cp[20:18]});
            push_utf8({2'b10, cp[17:12]});
            push_utf8({2'b10, cp[11:6]});
            push_utf8({2'b10, cp[5:0]});
        end
    endtask

    // Handles one complete UTF-16 code unit, pairing surrogates where it can.
    task automatic predict_unit(input logic [15:0] u);
        logic is_high;
        logic is_low;
        is_high = (u >= HighFirst) && (u <= HighLast);
        is_low = (u >= LowFirst) && (u <= LowLast);
        if (high_waiting && is_low)
        begin
            // The low ten bits of each surrogate carry the payload.
            push_code_point(21'h010000 + {1'b0, waiting_high[9:0], u[9:0]});
            high_waiting = 1'b0;
            waiting_high = '0;
        end
        else
        begin
            if (high_waiting)
            begin
                push_code_point({5'b0, waiting_high});
                high_waiting = 1'b0;
                waiting_high = '0;
            end
            if (is_high)
            begin
                waiting_high = u;
                high_waiting = 1'b1;
            end
            else
                push_code_point({5'b0, u});
        end
    endtask

    // Works out every UTF-8 item caused by one accepted input byte.
    task automatic predict_utf8(input logic [7:0] b, input logic last);
        int before_n;
        utf8_item_t marker;
        before_n = utf8_expected.size();
        if (!unit_half_seen)
        begin
            unit_first_byte = b;
            unit_half_seen = 1'b1;
        end
        else
        begin
            // The byte order in force now, at the second byte, decides the assembly.
            unit_half_seen = 1'b0;
            predict_unit(cfg_big_endian ? {unit_first_byte, b} : {b, unit_first_byte});
            unit_first_byte = '0;
        end
        if (last)
        begin
            if (high_waiting)
                push_code_point({5'b0, waiting_high});
            high_waiting = 1'b0;
            waiting_high = '0;
            unit_half_seen = 1'b0;
            unit_first_byte = '0;
            if (utf8_expected.size() == before_n)
            begin
                marker.data = '0;
                marker.data_valid = 1'b0;
                marker.last = 1'b1;
                utf8_expected.insert(utf8_expected.size(), marker);
                end_markers++;
            end
            else
                utf8_expected[utf8_expected.size() - 1].last = 1'b1;
        end
    endtask

    // Offers one byte from a falling edge and holds it until the block takes it. The
    // prediction is made at the very edge of acceptance. Returns just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (tx_gaps && $urandom_range(0, 99) < 16)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        in_last = last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_utf8(b, last);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Sends one code unit in the byte order currently configured; last rides on its second byte.
    task automatic send_unit(input logic [15:0] u, input logic last);
        if (cfg_big_endian)
        begin
            send_byte(u[15:8], 1'b0);
            send_byte(u[7:0], last);
        end
        else
        begin
            send_byte(u[7:0], 1'b0);
            send_byte(u[15:8], last);
        end
    endtask

    // Writes the byte order register over the APB port, then reads it back.
    task automatic write_byte_order(input logic be);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = BigEndianAddr;
        pwdata = {{(ApbDataWidth - 1){1'b0}}, be};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        cfg_big_endian = be;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== {{(ApbDataWidth - 1){1'b0}}, be})
            report_mismatch("big_endian read-back", prdata, be);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every expected item has arrived, then lets any byte that causes no output
    // work its way through the pipeline before the block is treated as idle.
    task automatic wait_for_drain();
        while (utf8_expected.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed UTF-16 text with random content, salted with lone surrogates,
    // stray bytes that knock the pairing out of step, and stream ends in odd places.
    task automatic send_random_text(input int n_items);
        int stop_at;
        int pick;
        logic [15:0] u;
        logic [19:0] offset;
        logic last;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            last = ($urandom_range(0, 15) == 0);
            if (pick < 18)
                send_unit(16'($urandom_range(0, 16'h007F)), last);
            else if (pick < 33)
                send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
            else if (pick < 53)
            begin
                // Draw from a range the size of the three-byte part of the BMP minus the surrogate block, then
                // shift the top part up past it.
                u = 16'($urandom_range(16'h0800, 16'hF7FF));
                if (u >= HighFirst)
                    u = u + 16'h0800;
                send_unit(u, last);
            end
            else if (pick < 75)
            begin
                offset = 20'($urandom);
                send_unit({6'b110110, offset[19:10]}, 1'b0);
                send_unit({6'b110111, offset[9:0]}, last);
            end
            else if (pick < 80)
                send_unit({6'b110110, 10'($urandom)}, last);
            else if (pick < 85)
                send_unit({6'b110111, 10'($urandom)}, last);
            else
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // Boundaries of each encoding length, both surrogate extremes, a high surrogate displaced
    // by another, a lone low surrogate, a flush with a dangling byte, and a bare end marker.
    task automatic test_little_endian_units();
        write_byte_order(1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD83D, 1'b0);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_for_drain();
    endtask

    // The same decoding with the high byte first, ending the stream on a surrogate pair.
    task automatic test_big_endian_units();
        write_byte_order(1'b1);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b1);
        wait_for_drain();
    endtask

    // The first byte of a unit arrives under one byte order and the second under the other;
    // the order at the second byte must win.
    task automatic test_order_change_midstream();
        send_byte(8'h34, 1'b0);
        wait_for_drain();
        write_byte_order(1'b0);
        send_byte(8'h12, 1'b1);
        wait_for_drain();
    endtask

    // Random text in alternating byte orders; the third phase runs without any idling.
    task automatic test_random_text();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_for_drain();
            write_byte_order(1'(phase & 1));
            tx_gaps = (phase != 2);
            rx_gaps = (phase != 2);
            send_random_text(70);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // The receiver stops for a long stretch while the sender keeps offering items, so the
    // job queue fills and the block has to hold off its input.
    task automatic test_receiver_hold();
        hold_left = 200;
        send_random_text(40);
    endtask

    // The sender stops until every outstanding item has come out, then starts again.
    task automatic test_sender_pause();
        send_random_text(15);
        wait_for_drain();
        send_random_text(15);
    endtask

    // Receiver: ready is changed only at falling edges. A hold-off is counted down here.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
            hold_cycles_done++;
        end
        else if (rx_gaps && $urandom_range(0, 99) < 16)
            out_ready = 1'b0;
        else
            out_ready = 1'b1;
    end

    // Checker: every item the block hands over is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_utf8
        utf8_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (utf8_expected.size() == 0)
                report_mismatch("UTF-8 item with nothing expected", out_byte, 0);
            else
            begin
                want = utf8_expected.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (byte_valid !== want.data_valid)
                    report_mismatch("byte_valid", byte_valid, want.data_valid);
                if (out_last !== want.last)
                    report_mismatch("out_last", out_last, want.last);
            end
            utf8_checked++;
        end
    end

    // Main sequence: reset, then each test in turn, then drain and give the verdict.
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_little_endian_units();
        test_big_endian_units();
        test_order_change_midstream();
        test_random_text();
        test_receiver_hold();
        test_sender_pause();
        wait_for_drain();
        if (utf8_expected.size() != 0)
            report_mismatch("UTF-8 items never produced", utf8_expected.size(), 0);
        $display("Sent %0d UTF-16 bytes in both byte orders and checked %0d UTF-8 items,",
                 items_sent, utf8_checked);
        $display("including %0d bare end markers and a receiver hold-off of %0d cycles.",
                 end_markers, hold_cycles_done);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> utf16_to_utf8_transcoder_core.f
rtl/core/utt_pkg.sv
rtl/core/utt_front.sv
rtl/core/utt_queue.sv
rtl/core/utt_back.sv
rtl/core/utf16_to_utf8_transcoder_core.sv
tb/utf16_to_utf8_transcoder_core_tb.sv
